// ----- rtl/b32ce_pkg.sv -----
// b32ce_pkg: shared types and constants for the Bech32 checksum engine.
// Depends on nothing; used by b32ce_polymod, bech32_checksum_engine and the testbench.
package b32ce_pkg;

    localparam int RES_W  = 30;
    localparam int SYM_W  = 5;
    localparam int CHAR_W = 7;
    localparam int GEN_N  = 5;

    localparam logic [2:0] PAD_LAST  = 3'd5;
    localparam logic [2:0] EMIT_LAST = 3'd5;

    localparam logic [RES_W-1:0] RES_ONE = RES_W'(1);

    typedef logic [RES_W-1:0] res_t;
    typedef logic [SYM_W-1:0] sym_t;

    typedef enum logic [1:0] {
        CMD_PREFIX = 2'd0,
        CMD_DATA   = 2'd1,
        CMD_CREATE = 2'd2,
        CMD_VERIFY = 2'd3
    } cmd_t;

    function automatic res_t gen_coef(input int idx);
        res_t c;
        case (idx)
            0:       c = 30'h3b6a57b2;
            1:       c = 30'h26508e6d;
            2:       c = 30'h1ea119fa;
            3:       c = 30'h3d4233dd;
            4:       c = 30'h2a1462b3;
            default: c = '0;
        endcase
        return c;
    endfunction

endpackage

// ----- rtl/b32ce_polymod.sv -----
// b32ce_polymod: one Bech32 polymod step, the shared unit of the engine.
// Depends on b32ce_pkg for widths and generator constants.
module b32ce_polymod (
    input  b32ce_pkg::res_t res_in,
    input  b32ce_pkg::sym_t sym_in,
    output b32ce_pkg::res_t res_out
);

    logic [b32ce_pkg::SYM_W-1:0] top;
    b32ce_pkg::res_t             acc;

    always_comb begin
        top = res_in[b32ce_pkg::RES_W-1 -: b32ce_pkg::SYM_W];
        acc = {res_in[b32ce_pkg::RES_W-b32ce_pkg::SYM_W-1:0], sym_in};
        for (int i = 0; i < b32ce_pkg::GEN_N; i++) begin
            if (top[i]) begin
                acc = acc ^ b32ce_pkg::gen_coef(i);
            end
        end
        res_out = acc;
    end

endmodule

// ----- rtl/bech32_checksum_engine.sv -----
// bech32_checksum_engine: Bech32 polymod checksum over prefix and data beats.
// Depends on b32ce_pkg and b32ce_polymod.
//
// Prefix beats are taken while idle and land in an on-chip buffer. Once the
// prefix has been folded, each data beat goes straight through the single
// polymod step unit. The first data or finish beat of a message replays the
// buffer through that same unit, paced by the one buffer read port and its
// registered data. A create beat then pads the residue with zero symbols and
// gives six result beats; a verify beat gives one result beat. Each result
// beat waits for the output register to free. A message longer than
// MAX_PREFIX_CHARS prefix characters keeps the first ones and flags overflow
// on its results.
module bech32_checksum_engine #(
    parameter int MAX_PREFIX_CHARS = 64
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [1:0] s_command,
    input  logic [6:0] s_value,
    output logic       m_valid,
    input  logic       m_ready,
    output logic [4:0] m_symbol,
    output logic       m_checksum_ok,
    output logic       m_last,
    output logic       m_overflow
);

    localparam int CNT_W = $clog2(MAX_PREFIX_CHARS + 1);
    localparam int IDX_W = (MAX_PREFIX_CHARS > 1) ? $clog2(MAX_PREFIX_CHARS) : 1;
    localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_PREFIX_CHARS);

    typedef enum logic [7:0] {
        ST_IDLE   = 8'b0000_0001,
        ST_FOLDHI = 8'b0000_0010,
        ST_FOLDZ  = 8'b0000_0100,
        ST_FOLDLO = 8'b0000_1000,
        ST_APPLY  = 8'b0001_0000,
        ST_PAD    = 8'b0010_0000,
        ST_EMIT   = 8'b0100_0000,
        ST_VERIFY = 8'b1000_0000
    } state_t;

    state_t               state_reg, state_next;
    b32ce_pkg::res_t      residue_reg, residue_next;
    logic [CNT_W-1:0]     cnt_reg, cnt_next;
    logic [CNT_W-1:0]     rd_idx_reg, rd_idx_next;
    logic                 folded_reg, folded_next;
    logic                 ovf_reg, ovf_next;
    logic                 rd_vld_reg;
    logic [2:0]           step_cnt_reg, step_cnt_next;
    b32ce_pkg::cmd_t      pend_cmd_reg, pend_cmd_next;
    b32ce_pkg::sym_t      pend_sym_reg, pend_sym_next;

    logic                 m_valid_reg, m_valid_next;
    logic [4:0]           m_symbol_reg, m_symbol_next;
    logic                 m_ok_reg, m_ok_next;
    logic                 m_last_reg, m_last_next;
    logic                 m_ovf_reg, m_ovf_next;

    logic [b32ce_pkg::CHAR_W-1:0] mem [MAX_PREFIX_CHARS];
    logic [b32ce_pkg::CHAR_W-1:0] rd_data_reg;

    logic                 mem_we;
    logic                 issue;
    logic                 out_free;
    logic                 accept;
    b32ce_pkg::cmd_t      cmd_in;
    b32ce_pkg::sym_t      step_sym;
    b32ce_pkg::res_t      step_res;

    b32ce_polymod u_polymod (
        .res_in  (residue_reg),
        .sym_in  (step_sym),
        .res_out (step_res)
    );

    assign s_ready  = (state_reg == ST_IDLE);
    assign accept   = s_valid && s_ready;
    assign cmd_in   = b32ce_pkg::cmd_t'(s_command);
    assign out_free = !m_valid_reg || m_ready;
    assign issue    = ((state_reg == ST_FOLDHI) || (state_reg == ST_FOLDLO))
                      && (rd_idx_reg != cnt_reg);

    always_comb begin
        case (state_reg)
            ST_IDLE:   step_sym = s_value[4:0];
            ST_APPLY:  step_sym = pend_sym_reg;
            ST_FOLDHI: step_sym = {3'b000, rd_data_reg[6:5]};
            ST_FOLDLO: step_sym = rd_data_reg[4:0];
            default:   step_sym = '0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[cnt_reg[IDX_W-1:0]] <= s_value;
        end
        rd_data_reg <= mem[rd_idx_reg[IDX_W-1:0]];
    end

    always_comb begin
        state_next    = state_reg;
        residue_next  = residue_reg;
        cnt_next      = cnt_reg;
        rd_idx_next   = rd_idx_reg;
        folded_next   = folded_reg;
        ovf_next      = ovf_reg;
        step_cnt_next = step_cnt_reg;
        pend_cmd_next = pend_cmd_reg;
        pend_sym_next = pend_sym_reg;
        mem_we        = 1'b0;
        m_valid_next  = m_valid_reg && !m_ready;
        m_symbol_next = m_symbol_reg;
        m_ok_next     = m_ok_reg;
        m_last_next   = m_last_reg;
        m_ovf_next    = m_ovf_reg;

        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    case (cmd_in)
                        b32ce_pkg::CMD_PREFIX: begin
                            if (!folded_reg) begin
                                if (cnt_reg < MAX_CNT) begin
                                    mem_we   = 1'b1;
                                    cnt_next = cnt_reg + 1'b1;
                                end else begin
                                    ovf_next = 1'b1;
                                end
                            end
                        end
                        b32ce_pkg::CMD_DATA: begin
                            if (folded_reg) begin
                                residue_next = step_res;
                            end else begin
                                pend_cmd_next = cmd_in;
                                pend_sym_next = s_value[4:0];
                                rd_idx_next   = '0;
                                state_next    = ST_FOLDHI;
                            end
                        end
                        default: begin
                            pend_cmd_next = cmd_in;
                            rd_idx_next   = '0;
                            state_next    = folded_reg ? ST_APPLY : ST_FOLDHI;
                        end
                    endcase
                end
            end
            ST_FOLDHI: begin
                if (issue) begin
                    rd_idx_next = rd_idx_reg + 1'b1;
                end
                if (rd_vld_reg) begin
                    residue_next = step_res;
                end
                if (!issue && !rd_vld_reg) begin
                    state_next = ST_FOLDZ;
                end
            end
            ST_FOLDZ: begin
                residue_next = step_res;
                rd_idx_next  = '0;
                state_next   = ST_FOLDLO;
            end
            ST_FOLDLO: begin
                if (issue) begin
                    rd_idx_next = rd_idx_reg + 1'b1;
                end
                if (rd_vld_reg) begin
                    residue_next = step_res;
                end
                if (!issue && !rd_vld_reg) begin
                    folded_next = 1'b1;
                    state_next  = ST_APPLY;
                end
            end
            ST_APPLY: begin
                case (pend_cmd_reg)
                    b32ce_pkg::CMD_DATA: begin
                        residue_next = step_res;
                        state_next   = ST_IDLE;
                    end
                    b32ce_pkg::CMD_CREATE: begin
                        step_cnt_next = '0;
                        state_next    = ST_PAD;
                    end
                    default: begin
                        state_next = ST_VERIFY;
                    end
                endcase
            end
            ST_PAD: begin
                residue_next  = step_res;
                step_cnt_next = step_cnt_reg + 1'b1;
                if (step_cnt_reg == b32ce_pkg::PAD_LAST) begin
                    residue_next  = step_res ^ b32ce_pkg::RES_ONE;
                    step_cnt_next = '0;
                    state_next    = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (out_free) begin
                    m_valid_next  = 1'b1;
                    m_symbol_next = residue_reg[b32ce_pkg::RES_W-1 -: b32ce_pkg::SYM_W];
                    m_ok_next     = 1'b0;
                    m_last_next   = (step_cnt_reg == b32ce_pkg::EMIT_LAST);
                    m_ovf_next    = ovf_reg;
                    residue_next  = residue_reg << b32ce_pkg::SYM_W;
                    step_cnt_next = step_cnt_reg + 1'b1;
                    if (step_cnt_reg == b32ce_pkg::EMIT_LAST) begin
                        residue_next = b32ce_pkg::RES_ONE;
                        cnt_next     = '0;
                        folded_next  = 1'b0;
                        ovf_next     = 1'b0;
                        state_next   = ST_IDLE;
                    end
                end
            end
            ST_VERIFY: begin
                if (out_free) begin
                    m_valid_next  = 1'b1;
                    m_symbol_next = '0;
                    m_ok_next     = (residue_reg == b32ce_pkg::RES_ONE);
                    m_last_next   = 1'b1;
                    m_ovf_next    = ovf_reg;
                    residue_next  = b32ce_pkg::RES_ONE;
                    cnt_next      = '0;
                    folded_next   = 1'b0;
                    ovf_next      = 1'b0;
                    state_next    = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            residue_reg  <= b32ce_pkg::RES_ONE;
            cnt_reg      <= '0;
            rd_idx_reg   <= '0;
            folded_reg   <= 1'b0;
            ovf_reg      <= 1'b0;
            rd_vld_reg   <= 1'b0;
            step_cnt_reg <= '0;
            pend_cmd_reg <= b32ce_pkg::CMD_PREFIX;
            m_valid_reg  <= 1'b0;
        end else begin
            state_reg    <= state_next;
            residue_reg  <= residue_next;
            cnt_reg      <= cnt_next;
            rd_idx_reg   <= rd_idx_next;
            folded_reg   <= folded_next;
            ovf_reg      <= ovf_next;
            rd_vld_reg   <= issue;
            step_cnt_reg <= step_cnt_next;
            pend_cmd_reg <= pend_cmd_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        pend_sym_reg <= pend_sym_next;
        m_symbol_reg <= m_symbol_next;
        m_ok_reg     <= m_ok_next;
        m_last_reg   <= m_last_next;
        m_ovf_reg    <= m_ovf_next;
    end

    assign m_valid       = m_valid_reg;
    assign m_symbol      = m_symbol_reg;
    assign m_checksum_ok = m_ok_reg;
    assign m_last        = m_last_reg;
    assign m_overflow    = m_ovf_reg;

endmodule

// ----- rtl/b32ce_checker.sv -----
// b32ce_checker: port-level assertions for bech32_checksum_engine.
// Bound to the top level below; needs nothing else.
module b32ce_checker (
    input logic       aclk,
    input logic       aresetn,
    input logic       m_valid,
    input logic       m_ready,
    input logic [4:0] m_symbol,
    input logic       m_checksum_ok,
    input logic       m_last,
    input logic       m_overflow
);

    // result beat holds while stalled
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_symbol) && $stable(m_last)
            && $stable(m_checksum_ok) && $stable(m_overflow))
        else $error("result beat changed while stalled");

    a_ok_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_checksum_ok |-> m_last)
        else $error("checksum_ok on a beat that is not last");

    a_ok_sym: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_checksum_ok |-> m_symbol == 5'd0)
        else $error("verify beat carries a nonzero symbol");

    a_reset_quiet: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result beat valid right after reset");

endmodule

bind bech32_checksum_engine b32ce_checker u_b32ce_checker (
    .aclk          (aclk),
    .aresetn       (aresetn),
    .m_valid       (m_valid),
    .m_ready       (m_ready),
    .m_symbol      (m_symbol),
    .m_checksum_ok (m_checksum_ok),
    .m_last        (m_last),
    .m_overflow    (m_overflow)
);

// ----- tb/tb_bech32_checksum_engine.sv -----
// tb_bech32_checksum_engine: self-checking testbench for the Bech32 checksum engine.
// Depends on b32ce_pkg and bech32_checksum_engine. A polymod predictor built into
// the bench works out every result beat, which is then checked field by field.
module tb_bech32_checksum_engine;

    localparam int MAX_HRP        = 64;
    localparam int TARGET_BEATS   = 480;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int DRAIN_CYCLES   = 300;
    localparam logic [b32ce_pkg::GEN_N*b32ce_pkg::RES_W-1:0] POLY_GEN = {
        30'h2a1462b3, 30'h3d4233dd, 30'h1ea119fa, 30'h26508e6d, 30'h3b6a57b2
    };

    typedef enum logic [1:0] {
        PH_STEADY,
        PH_SEND_IDLE,
        PH_RECV_STALL,
        PH_BOTH
    } phase_t;

    typedef struct {
        b32ce_pkg::cmd_t cmd;
        logic [6:0]      value;
        bit              hold;
        phase_t          phase;
    } msg_beat_t;

    typedef struct packed {
        logic [4:0] symbol;
        logic       ok;
        logic       last;
        logic       ovf;
    } chk_result_t;

    logic       aclk          = 1'b0;
    logic       aresetn       = 1'b0;
    logic       s_valid       = 1'b0;
    logic       s_ready;
    logic [1:0] s_command     = 2'd0;
    logic [6:0] s_value       = 7'd0;
    logic       m_valid;
    logic       m_ready       = 1'b0;
    logic [4:0] m_symbol;
    logic       m_checksum_ok;
    logic       m_last;
    logic       m_overflow;

    msg_beat_t   pending_beats [$];
    msg_beat_t   next_beat;
    chk_result_t expected_results [$];
    phase_t      cur_phase = PH_STEADY;
    logic        in_taken  = 1'b0;

    // predictor state
    b32ce_pkg::res_t chk_residue  = b32ce_pkg::RES_ONE;
    logic [6:0]      hrp_chars [MAX_HRP];
    int              hrp_len      = 0;
    bit              hrp_folded   = 1'b0;
    bit              hrp_overflow = 1'b0;

    int beats_total      = 0;
    int beats_counted    = 0;
    int beats_accepted   = 0;
    int results_seen     = 0;
    int err_count        = 0;
    int idle_cycles      = 0;
    int created_sums     = 0;
    int verified_sums    = 0;
    int passing_sums     = 0;
    int overflow_msgs    = 0;

    bech32_checksum_engine #(
        .MAX_PREFIX_CHARS(MAX_HRP)
    ) u_top (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_command     (s_command),
        .s_value       (s_value),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_symbol      (m_symbol),
        .m_checksum_ok (m_checksum_ok),
        .m_last        (m_last),
        .m_overflow    (m_overflow)
    );

    always #2 aclk = ~aclk;

    function automatic int send_idle_pct(input phase_t ph);
        case (ph)
            PH_SEND_IDLE: return 46;
            PH_BOTH:      return 16;
            default:      return 0;
        endcase
    endfunction

    function automatic int recv_stall_pct(input phase_t ph);
        case (ph)
            PH_RECV_STALL: return 46;
            PH_BOTH:       return 16;
            default:       return 0;
        endcase
    endfunction

    function automatic b32ce_pkg::res_t polymod_step(input b32ce_pkg::res_t r,
                                                     input b32ce_pkg::sym_t s);
        b32ce_pkg::res_t acc;
        int              i;
        acc = {r[b32ce_pkg::RES_W-b32ce_pkg::SYM_W-1:0], s};
        for (i = 0; i < b32ce_pkg::GEN_N; i++) begin
            if (r[b32ce_pkg::RES_W-b32ce_pkg::SYM_W+i]) begin
                acc ^= POLY_GEN[i*b32ce_pkg::RES_W +: b32ce_pkg::RES_W];
            end
        end
        return acc;
    endfunction

    task automatic report_error(input string msg);
        $display("%0t: ERROR %s", $time, msg);
        err_count++;
    endtask

    task automatic fold_hrp();
        int i;
        if (!hrp_folded) begin
            for (i = 0; i < hrp_len; i++) begin
                chk_residue = polymod_step(chk_residue,
                                           b32ce_pkg::sym_t'(hrp_chars[i] >> 5));
            end
            chk_residue = polymod_step(chk_residue, '0);
            for (i = 0; i < hrp_len; i++) begin
                chk_residue = polymod_step(chk_residue, hrp_chars[i][4:0]);
            end
            hrp_folded = 1'b1;
        end
    endtask

    task automatic start_message();
        if (hrp_overflow) begin
            overflow_msgs++;
        end
        chk_residue  = b32ce_pkg::RES_ONE;
        hrp_len      = 0;
        hrp_folded   = 1'b0;
        hrp_overflow = 1'b0;
    endtask

    task automatic absorb_beat(input b32ce_pkg::cmd_t cmd, input logic [6:0] value);
        b32ce_pkg::res_t sum;
        chk_result_t     r;
        int              k;
        case (cmd)
            b32ce_pkg::CMD_PREFIX: begin
                if (!hrp_folded) begin
                    if (hrp_len < MAX_HRP) begin
                        hrp_chars[hrp_len] = value;
                        hrp_len++;
                    end else begin
                        hrp_overflow = 1'b1;
                    end
                end
            end
            b32ce_pkg::CMD_DATA: begin
                fold_hrp();
                chk_residue = polymod_step(chk_residue, value[4:0]);
            end
            b32ce_pkg::CMD_CREATE: begin
                fold_hrp();
                for (k = 0; k < 6; k++) begin
                    chk_residue = polymod_step(chk_residue, '0);
                end
                sum = chk_residue ^ b32ce_pkg::RES_ONE;
                for (k = 0; k < 6; k++) begin
                    r.symbol = sum[5*(5-k) +: 5];
                    r.ok     = 1'b0;
                    r.last   = (k == 5);
                    r.ovf    = hrp_overflow;
                    expected_results = {expected_results, r};
                end
                created_sums++;
                start_message();
            end
            default: begin
                fold_hrp();
                r.symbol = '0;
                r.ok     = (chk_residue == b32ce_pkg::RES_ONE);
                r.last   = 1'b1;
                r.ovf    = hrp_overflow;
                expected_results = {expected_results, r};
                verified_sums++;
                if (r.ok) begin
                    passing_sums++;
                end
                start_message();
            end
        endcase
    endtask

    task automatic check_result();
        chk_result_t want;
        results_seen++;
        if (expected_results.size() == 0) begin
            report_error($sformatf("result beat %0d arrived with nothing expected", results_seen));
            return;
        end
        want = expected_results.pop_front();
        if (m_symbol !== want.symbol) begin
            report_error($sformatf("beat %0d symbol: got %0d, expected %0d",
                                   results_seen, m_symbol, want.symbol));
        end
        if (m_checksum_ok !== want.ok) begin
            report_error($sformatf("beat %0d checksum_ok: got %0b, expected %0b",
                                   results_seen, m_checksum_ok, want.ok));
        end
        if (m_last !== want.last) begin
            report_error($sformatf("beat %0d last: got %0b, expected %0b",
                                   results_seen, m_last, want.last));
        end
        if (m_overflow !== want.ovf) begin
            report_error($sformatf("beat %0d overflow: got %0b, expected %0b",
                                   results_seen, m_overflow, want.ovf));
        end
    endtask

    task automatic push_beat(input b32ce_pkg::cmd_t cmd, input logic [6:0] value,
                             input bit hold, input bit ignored, input phase_t ph);
        msg_beat_t b;
        b.cmd   = cmd;
        b.value = value;
        b.hold  = hold;
        b.phase = ph;
        pending_beats = {pending_beats, b};
        beats_total++;
        if (!ignored) begin
            beats_counted++;
        end
    endtask

    // One message: prefix, data (now and then with one stray prefix beat), then a finish. For verify,
    // the real checksum is appended and one data or checksum symbol is optionally corrupted.
    task automatic queue_message(input int n_hrp, input int n_data,
                                 input b32ce_pkg::cmd_t fin, input bit good_sum,
                                 input bit hold, input phase_t ph);
        logic [6:0]      hrp [$];
        logic [6:0]      body [$];
        logic [6:0]      ch;
        b32ce_pkg::res_t r;
        b32ce_pkg::res_t sum;
        int              i;
        int              n_kept;
        int              noise_at;
        bit              first;
        first = hold;
        for (i = 0; i < n_hrp; i++) begin
            if ($urandom_range(99) < 70) begin
                ch = 7'($urandom_range(33, 126));
            end else begin
                ch = 7'($urandom_range(127));
            end
            hrp = {hrp, ch};
        end
        for (i = 0; i < n_data; i++) begin
            ch = 7'($urandom_range(31));
            if ($urandom_range(7) == 0) begin
                ch[6:5] = 2'($urandom_range(1, 3));
            end
            body = {body, ch};
        end
        if (fin == b32ce_pkg::CMD_VERIFY) begin
            n_kept = (n_hrp < MAX_HRP) ? n_hrp : MAX_HRP;
            r = b32ce_pkg::RES_ONE;
            for (i = 0; i < n_kept; i++) begin
                ch = hrp[i];
                r  = polymod_step(r, b32ce_pkg::sym_t'(ch >> 5));
            end
            r = polymod_step(r, '0);
            for (i = 0; i < n_kept; i++) begin
                ch = hrp[i];
                r  = polymod_step(r, ch[4:0]);
            end
            for (i = 0; i < n_data; i++) begin
                ch = body[i];
                r  = polymod_step(r, ch[4:0]);
            end
            for (i = 0; i < 6; i++) begin
                r = polymod_step(r, '0);
            end
            sum = r ^ b32ce_pkg::RES_ONE;
            for (i = 0; i < 6; i++) begin
                body = {body, 7'(sum[5*(5-i) +: 5])};
            end
            if (!good_sum) begin
                i = $urandom_range(body.size() - 1);
                body[i] = body[i] ^ 7'($urandom_range(1, 31));
            end
        end
        noise_at = -1;
        if (body.size() > 0 && $urandom_range(9) == 0) begin
            noise_at = $urandom_range(body.size() - 1);
        end
        for (i = 0; i < hrp.size(); i++) begin
            push_beat(b32ce_pkg::CMD_PREFIX, hrp[i], first, 1'b0, ph);
            first = 1'b0;
        end
        for (i = 0; i < body.size(); i++) begin
            push_beat(b32ce_pkg::CMD_DATA, body[i], first, 1'b0, ph);
            first = 1'b0;
            if (i == noise_at) begin
                push_beat(b32ce_pkg::CMD_PREFIX, 7'($urandom_range(127)), 1'b0, 1'b1, ph);
            end
        end
        push_beat(fin, 7'($urandom_range(127)), first, 1'b0, ph);
    endtask

    // driver: new beat only once the current one is gone, and a held beat only once no results are pending
    always @(negedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else if (!s_valid || in_taken) begin
            if (pending_beats.size() != 0
                    && !(pending_beats[0].hold && expected_results.size() != 0)
                    && $urandom_range(99) >= send_idle_pct(pending_beats[0].phase)) begin
                next_beat = pending_beats.pop_front();
                s_valid   <= 1'b1;
                s_command <= next_beat.cmd;
                s_value   <= next_beat.value;
                cur_phase <= next_beat.phase;
            end else begin
                s_valid <= 1'b0;
            end
        end
        m_ready <= ($urandom_range(99) >= recv_stall_pct(cur_phase));
    end

    // monitor and watchdog
    always @(posedge aclk) begin
        if (!aresetn) begin
            in_taken <= 1'b0;
        end else begin
            in_taken <= s_valid && s_ready;
            if (m_valid && m_ready) begin
                check_result();
            end
            if (s_valid && s_ready) begin
                absorb_beat(b32ce_pkg::cmd_t'(s_command), s_value);
                beats_accepted++;
            end
            if ((m_valid && m_ready) || (s_valid && s_ready)) begin
                idle_cycles = 0;
            end else begin
                idle_cycles++;
                if (idle_cycles >= WATCHDOG_LIMIT) begin
                    $display("%0t: watchdog: no beat moved for %0d cycles, %0d results pending",
                             $time, idle_cycles, expected_results.size());
                    $display("tb_bech32_checksum_engine: FAIL");
                    $finish;
                end
            end
        end
    end

    initial begin
        int              msg;
        int              n_hrp;
        int              n_data;
        int              roll;
        int              i;
        int              n;
        phase_t          ph;
        b32ce_pkg::cmd_t fin;

        // directed: empty messages, field extremes, ignored bits and beats
        push_beat(b32ce_pkg::CMD_CREATE, 7'h7f, 1'b0, 1'b0, PH_STEADY);
        push_beat(b32ce_pkg::CMD_VERIFY, 7'h00, 1'b0, 1'b0, PH_STEADY);
        push_beat(b32ce_pkg::CMD_PREFIX, 7'h00, 1'b0, 1'b0, PH_STEADY);
        push_beat(b32ce_pkg::CMD_PREFIX, 7'h7f, 1'b0, 1'b0, PH_STEADY);
        push_beat(b32ce_pkg::CMD_DATA,   7'h00, 1'b0, 1'b0, PH_STEADY);
        push_beat(b32ce_pkg::CMD_DATA,   7'h7f, 1'b0, 1'b0, PH_STEADY);
        push_beat(b32ce_pkg::CMD_DATA,   7'h1f, 1'b0, 1'b0, PH_STEADY);
        push_beat(b32ce_pkg::CMD_PREFIX, 7'h61, 1'b0, 1'b1, PH_STEADY);
        push_beat(b32ce_pkg::CMD_DATA,   7'h60, 1'b0, 1'b0, PH_STEADY);
        push_beat(b32ce_pkg::CMD_CREATE, 7'h2a, 1'b0, 1'b0, PH_STEADY);
        push_beat(b32ce_pkg::CMD_PREFIX, 7'h62, 1'b1, 1'b0, PH_STEADY);
        push_beat(b32ce_pkg::CMD_PREFIX, 7'h63, 1'b0, 1'b0, PH_STEADY);
        push_beat(b32ce_pkg::CMD_VERIFY, 7'h55, 1'b0, 1'b0, PH_STEADY);
        queue_message(3, 2, b32ce_pkg::CMD_VERIFY, 1'b1, 1'b1, PH_STEADY);
        queue_message(2, 1, b32ce_pkg::CMD_VERIFY, 1'b0, 1'b0, PH_STEADY);

        msg = 0;
        while (beats_counted < TARGET_BEATS) begin
            ph   = phase_t'((msg / 3) % 4);
            roll = $urandom_range(99);
            if (roll < 10) begin
                // random junk commands, then a verify to close the message
                n = $urandom_range(1, 8);
                for (i = 0; i < n; i++) begin
                    push_beat(b32ce_pkg::cmd_t'($urandom_range(3)), 7'($urandom_range(127)),
                              1'b0, 1'b0, ph);
                end
                push_beat(b32ce_pkg::CMD_VERIFY, 7'($urandom_range(127)), 1'b0, 1'b0, ph);
            end else begin
                roll = $urandom_range(99);
                if (msg == 0 || roll < 5) begin
                    n_hrp = MAX_HRP + $urandom_range(1, 3);
                end else if (roll < 8) begin
                    n_hrp = MAX_HRP;
                end else begin
                    n_hrp = $urandom_range(0, 12);
                end
                n_data = $urandom_range(0, 20);
                fin    = $urandom_range(1) ? b32ce_pkg::CMD_CREATE : b32ce_pkg::CMD_VERIFY;
                queue_message(n_hrp, n_data, fin, $urandom_range(99) < 70,
                              (msg % 5) == 4, ph);
            end
            msg++;
        end

        repeat (4) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        while (beats_accepted < beats_total || expected_results.size() != 0) begin
            @(negedge aclk);
        end
        repeat (DRAIN_CYCLES) @(posedge aclk);
        @(negedge aclk);
        if (expected_results.size() != 0) begin
            report_error($sformatf("%0d result beats never arrived", expected_results.size()));
        end

        $display("run covered %0d input beats and %0d result beats over %0d random messages",
                 beats_accepted, results_seen, msg);
        $display("%0d checksums created, %0d verified (%0d good), %0d overflowed prefixes",
                 created_sums, verified_sums, passing_sums, overflow_msgs);
        if (err_count == 0) begin
            $display("tb_bech32_checksum_engine: PASS");
        end else begin
            $display("tb_bech32_checksum_engine: FAIL");
        end
        $finish;
    end

endmodule
